FILE: rtl/core/gli_pkg.sv
// shared types, command codes and arctangent table for the galvo line interpolator
package gli_pkg;

	localparam logic [2:0] CFG_FOCAL  = 3'd0;
	localparam logic [2:0] CFG_MIRROR = 3'd1;
	localparam logic [2:0] CFG_STEP   = 3'd2;
	localparam logic [2:0] CFG_SCALE  = 3'd3;
	localparam logic [2:0] CFG_CENTER = 3'd4;

	typedef struct packed {
		logic signed [23:0] goal_x;
		logic signed [23:0] goal_y;
	} in_item_t;

	typedef struct packed {
		logic [15:0] dac_x;
		logic [15:0] dac_y;
		logic        last_point;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_DSQ,
		OP_DADD,
		OP_SQRT,
		OP_DIVN,
		OP_SATN,
		OP_GOAL,
		OP_DIVX,
		OP_PX,
		OP_DIVY,
		OP_PY,
		OP_FSQ,
		OP_YADD,
		OP_SM,
		OP_DEN,
		OP_XNUM,
		OP_ATANX,
		OP_MULX,
		OP_CODEX,
		OP_ATANY,
		OP_MULY,
		OP_CODEY,
		OP_EMIT,
		OP_NEXT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic n_zero;
		logic last;
		logic out_free;
	} sts_t;

	// atan(2^-i) in Q2.30, truncated
	function automatic logic [29:0] atan_entry(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'h3243F6A8;
			5'd1:  v = 30'h1DAC6705;
			5'd2:  v = 30'h0FADBAFC;
			5'd3:  v = 30'h07F56EA6;
			5'd4:  v = 30'h03FEAB76;
			5'd5:  v = 30'h01FFD55B;
			5'd6:  v = 30'h00FFFAAA;
			5'd7:  v = 30'h007FFF55;
			5'd8:  v = 30'h003FFFEA;
			5'd9:  v = 30'h001FFFFD;
			5'd10: v = 30'h000FFFFF;
			5'd11: v = 30'h0007FFFF;
			5'd12: v = 30'h0003FFFF;
			5'd13: v = 30'h0001FFFF;
			5'd14: v = 30'h0000FFFF;
			5'd15: v = 30'h00007FFF;
			5'd16: v = 30'h00003FFF;
			5'd17: v = 30'h00001FFF;
			5'd18: v = 30'h00000FFF;
			5'd19: v = 30'h000007FF;
			5'd20: v = 30'h000003FF;
			5'd21: v = 30'h000001FF;
			5'd22: v = 30'h000000FF;
			5'd23: v = 30'h0000007F;
			5'd24: v = 30'h0000003F;
			5'd25: v = 30'h0000001F;
			5'd26: v = 30'h0000000F;
			5'd27: v = 30'h00000008;
			5'd28: v = 30'h00000004;
			5'd29: v = 30'h00000002;
			5'd30: v = 30'h00000001;
			default: v = 30'h00000000;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/core/gli_cordic.sv
// iterative vectoring cordic giving atan(num/den) in Q2.30
module gli_cordic (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [31:0] angle
);
	import gli_pkg::*;

	typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} phase_t;

	phase_t             phase_q;
	logic               done_q;
	logic [31:0]        angle_q;
	logic signed [65:0] x_q, y_q;
	logic [63:0]        mx_q;
	logic signed [32:0] z_q;
	logic [4:0]         i_q;

	logic               stop_c;
	logic               ypos_c;
	logic signed [65:0] xs_c, ys_c;
	logic signed [32:0] tab_c;

	assign stop_c = (y_q == '0) || (i_q == 5'd31);
	assign ypos_c = !y_q[65] && (y_q != '0);
	assign xs_c   = x_q >>> i_q;
	assign ys_c   = y_q >>> i_q;
	assign tab_c  = signed'({3'b000, atan_entry(i_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= C_IDLE;
			done_q  <= 1'b0;
			angle_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				C_IDLE: begin
					if (start) begin
						if (num == '0) begin
							angle_q <= '0;
							done_q  <= 1'b1;
						end else begin
							phase_q <= C_NORM;
						end
					end
				end
				C_NORM: begin
					if (mx_q[63:60] != '0) begin
						phase_q <= C_ITER;
					end
				end
				C_ITER: begin
					if (stop_c) begin
						angle_q <= z_q[32] ? 32'd0 : z_q[31:0];
						done_q  <= 1'b1;
						phase_q <= C_IDLE;
					end
				end
				default: phase_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == C_IDLE && start) begin
			x_q  <= signed'({2'b00, den});
			y_q  <= signed'({2'b00, num});
			mx_q <= (num > den) ? num : den;
			z_q  <= '0;
			i_q  <= '0;
		end else if (phase_q == C_NORM) begin
			if (mx_q[63:52] == '0) begin
				x_q  <= x_q <<< 8;
				y_q  <= y_q <<< 8;
				mx_q <= mx_q << 8;
			end else if (mx_q[63:60] == '0) begin
				x_q  <= x_q <<< 1;
				y_q  <= y_q <<< 1;
				mx_q <= mx_q << 1;
			end
		end else if (phase_q == C_ITER && !stop_c) begin
			if (ypos_c) begin
				x_q <= x_q + ys_c;
				y_q <= y_q - xs_c;
				z_q <= z_q + tab_c;
			end else begin
				x_q <= x_q - ys_c;
				y_q <= y_q + xs_c;
				z_q <= z_q - tab_c;
			end
			i_q <= i_q + 5'd1;
		end
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

FILE: rtl/core/gli_dp.sv
// datapath: config registers, shared multiplier, sqrt and divider, point mapping
module gli_dp #(
	parameter int MAX_STEPS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gli_pkg::cmd_t      cmd,
	output gli_pkg::sts_t      sts,
	input  logic               in_fire,
	input  gli_pkg::in_item_t  in_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               out_valid,
	output gli_pkg::out_item_t out_data,
	input  logic               out_ready
);
	import gli_pkg::*;

	localparam int NW = $clog2(MAX_STEPS + 1);
	localparam int DW = 24 + NW + 2;
	localparam int CW = $clog2(DW + 1);
	localparam logic [CW-1:0] SQ_ITER = CW'(26);

	logic [22:0]        focal_q, mirror_q, step_q;
	logic [31:0]        scale_q;
	logic [15:0]        center_q;
	logic signed [23:0] start_x_q, start_y_q;
	logic signed [23:0] goal_x_q, goal_y_q, px_q, py_q;
	logic               negx_q, negy_q;
	logic [23:0]        ux_q, uy_q, ax_q, ay_q;
	logic [51:0]        t_q;
	logic [NW-1:0]      n_q, k_q;
	logic               last_q;
	logic [24:0]        sm_q;
	logic [49:0]        den_q;
	logic [47:0]        xnum_q;
	logic [63:0]        prod_q;
	logic [15:0]        dacx_q, dacy_q;
	logic [51:0]        rad_q;
	logic [25:0]        root_q;
	logic [29:0]        srem_q;
	logic               sq_busy_q;
	logic [DW-1:0]      dvd_q;
	logic [22:0]        dvs_q;
	logic [23:0]        drem_q;
	logic               dv_busy_q;
	logic [CW-1:0]      cnt_q;
	logic               sd_done_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic signed [24:0] dx_c, dy_c;
	logic [24:0]        ux_c, uy_c;
	logic [29:0]        srem2_c, strial_c;
	logic               sge_c;
	logic [23:0]        drem2_c;
	logic               dge_c;
	logic [31:0]        mul_a, mul_b;
	logic [63:0]        mul_p;
	logic [23:0]        ksrc_c;
	logic [NW+23:0]     kux_c;
	logic [DW-1:0]      num_c;
	logic [23:0]        fm_c;
	logic [23:0]        axp_c, ayp_c;
	logic [63:0]        rnd_c;
	logic [17:0]        c_c;
	logic [18:0]        csum_c;
	logic               cneg_c;
	logic [15:0]        code_c;
	logic               cd_start, cd_done;
	logic [63:0]        cd_num, cd_den;
	logic [31:0]        cd_angle;

	assign dx_c = {in_data.goal_x[23], in_data.goal_x} - {start_x_q[23], start_x_q};
	assign dy_c = {in_data.goal_y[23], in_data.goal_y} - {start_y_q[23], start_y_q};
	assign ux_c = dx_c[24] ? 25'(-dx_c) : 25'(dx_c);
	assign uy_c = dy_c[24] ? 25'(-dy_c) : 25'(dy_c);

	assign srem2_c  = {srem_q[27:0], rad_q[51:50]};
	assign strial_c = {2'b00, root_q, 2'b01};
	assign sge_c    = srem2_c >= strial_c;
	assign drem2_c  = {drem_q[22:0], dvd_q[DW-1]};
	assign dge_c    = drem2_c >= {1'b0, dvs_q};

	assign fm_c  = {1'b0, focal_q} + {1'b0, mirror_q};
	assign axp_c = px_q[23] ? 24'(-px_q) : 24'(px_q);
	assign ayp_c = py_q[23] ? 24'(-py_q) : 24'(py_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_DSQ:  begin mul_a = 32'(ux_q);    mul_b = 32'(ux_q);    end
			OP_DADD: begin mul_a = 32'(uy_q);    mul_b = 32'(uy_q);    end
			OP_FSQ:  begin mul_a = 32'(focal_q); mul_b = 32'(focal_q); end
			OP_YADD: begin mul_a = 32'(ay_q);    mul_b = 32'(ay_q);    end
			OP_DEN:  begin mul_a = 32'(sm_q);    mul_b = 32'(sm_q);    end
			OP_XNUM: begin mul_a = 32'(ax_q);    mul_b = 32'(fm_c);    end
			OP_MULX: begin mul_a = cd_angle;     mul_b = scale_q;      end
			OP_MULY: begin mul_a = cd_angle;     mul_b = scale_q;      end
			default: begin mul_a = '0;           mul_b = '0;           end
		endcase
	end
	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	// rounded step numerator 2*k*u + n
	assign ksrc_c = (cmd.op == OP_DIVY) ? uy_q : ux_q;
	assign kux_c  = {{24{1'b0}}, k_q} * {{NW{1'b0}}, ksrc_c};
	assign num_c  = {1'b0, kux_c, 1'b0} + DW'(n_q);

	assign rnd_c  = prod_q + (64'd1 << 45);
	assign c_c    = rnd_c[63:46];
	assign csum_c = {3'b000, center_q} + {1'b0, c_c};
	assign cneg_c = (cmd.op == OP_CODEX) ? px_q[23] : py_q[23];
	always_comb begin
		if (cneg_c) begin
			code_c = ({2'b00, center_q} > c_c) ? (center_q - c_c[15:0]) : 16'd0;
		end else begin
			code_c = (csum_c > 19'd65535) ? 16'hFFFF : csum_c[15:0];
		end
	end

	assign cd_start = (cmd.op == OP_ATANX) || (cmd.op == OP_ATANY);
	assign cd_num   = (cmd.op == OP_ATANX) ? 64'(xnum_q) : 64'(ay_q);
	assign cd_den   = (cmd.op == OP_ATANX) ? 64'(den_q) : 64'(focal_q);

	gli_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cd_start),
		.num    (cd_num),
		.den    (cd_den),
		.done   (cd_done),
		.angle  (cd_angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q     <= 23'd76800;
			mirror_q    <= 23'd2560;
			step_q      <= 23'd256;
			scale_q     <= 32'h8000_0000;
			center_q    <= 16'd32767;
			start_x_q   <= '0;
			start_y_q   <= '0;
			out_valid_q <= 1'b0;
			sq_busy_q   <= 1'b0;
			dv_busy_q   <= 1'b0;
			cnt_q       <= '0;
			sd_done_q   <= 1'b0;
		end else begin
			sd_done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_FOCAL:  focal_q  <= cfg_data[22:0];
					CFG_MIRROR: mirror_q <= cfg_data[22:0];
					CFG_STEP:   step_q   <= cfg_data[22:0];
					CFG_SCALE:  scale_q  <= cfg_data;
					CFG_CENTER: center_q <= cfg_data[15:0];
					default:    ;
				endcase
			end
			if (cmd.op == OP_SQRT) begin
				sq_busy_q <= 1'b1;
				cnt_q     <= SQ_ITER;
			end else if (cmd.op == OP_DIVN || cmd.op == OP_DIVX || cmd.op == OP_DIVY) begin
				dv_busy_q <= 1'b1;
				cnt_q     <= CW'(DW);
			end else if (sq_busy_q || dv_busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					sq_busy_q <= 1'b0;
					dv_busy_q <= 1'b0;
					sd_done_q <= 1'b1;
				end
			end
			if (cmd.op == OP_NEXT && last_q) begin
				start_x_q <= goal_x_q;
				start_y_q <= goal_y_q;
			end
			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			goal_x_q <= in_data.goal_x;
			goal_y_q <= in_data.goal_y;
			negx_q   <= dx_c[24];
			negy_q   <= dy_c[24];
			ux_q     <= ux_c[23:0];
			uy_q     <= uy_c[23:0];
		end
		if (sq_busy_q) begin
			rad_q  <= {rad_q[49:0], 2'b00};
			srem_q <= sge_c ? (srem2_c - strial_c) : srem2_c;
			root_q <= {root_q[24:0], sge_c};
		end
		if (dv_busy_q) begin
			dvd_q  <= {dvd_q[DW-2:0], dge_c};
			drem_q <= dge_c ? (drem2_c - {1'b0, dvs_q}) : drem2_c;
		end
		case (cmd.op)
			OP_DSQ:  t_q <= mul_p[51:0];
			OP_DADD: t_q <= t_q + mul_p[51:0];
			OP_SQRT: begin
				rad_q  <= t_q;
				root_q <= '0;
				srem_q <= '0;
			end
			OP_DIVN: begin
				dvd_q  <= DW'(root_q);
				dvs_q  <= (step_q == '0) ? 23'd1 : step_q;
				drem_q <= '0;
			end
			OP_SATN: begin
				n_q <= (dvd_q > DW'(MAX_STEPS)) ? NW'(MAX_STEPS) : dvd_q[NW-1:0];
				k_q <= NW'(1);
			end
			OP_GOAL: begin
				px_q   <= goal_x_q;
				py_q   <= goal_y_q;
				last_q <= 1'b1;
			end
			OP_DIVX, OP_DIVY: begin
				dvd_q  <= num_c;
				dvs_q  <= 23'({n_q, 1'b0});
				drem_q <= '0;
			end
			OP_PX: px_q <= negx_q ? (start_x_q - signed'(dvd_q[23:0]))
				: (start_x_q + signed'(dvd_q[23:0]));
			OP_PY: begin
				py_q   <= negy_q ? (start_y_q - signed'(dvd_q[23:0]))
					: (start_y_q + signed'(dvd_q[23:0]));
				last_q <= (k_q == n_q);
			end
			OP_FSQ: begin
				t_q  <= mul_p[51:0];
				ax_q <= axp_c;
				ay_q <= ayp_c;
			end
			OP_YADD:  t_q    <= t_q + mul_p[51:0];
			OP_SM:    sm_q   <= {1'b0, root_q[23:0]} + {2'b00, mirror_q};
			OP_DEN:   den_q  <= mul_p[49:0];
			OP_XNUM:  xnum_q <= mul_p[47:0];
			OP_MULX:  prod_q <= mul_p;
			OP_MULY:  prod_q <= mul_p;
			OP_CODEX: dacx_q <= code_c;
			OP_CODEY: dacy_q <= code_c;
			OP_EMIT: begin
				out_q.dac_x      <= dacx_q;
				out_q.dac_y      <= dacy_q;
				out_q.last_point <= last_q;
			end
			OP_NEXT: begin
				if (!last_q) begin
					k_q <= k_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign sts.done     = sd_done_q | cd_done;
	assign sts.n_zero   = (n_q == '0);
	assign sts.last     = last_q;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

FILE: rtl/core/gli_ctrl.sv
// sequencer issuing datapath commands for each move and point
module gli_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  gli_pkg::sts_t sts,
	output gli_pkg::cmd_t cmd,
	output logic          in_ready
);
	import gli_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DSQ, S_DADD, S_SQRT, S_DIVN, S_SATN, S_BRANCH, S_GOAL,
		S_DIVX, S_PX, S_DIVY, S_PY, S_FSQ, S_YADD, S_SQ2, S_SM, S_DEN, S_XNUM,
		S_ATANX, S_MULX, S_CODEX, S_ATANY, S_MULY, S_CODEY, S_EMITW, S_EMIT,
		S_NEXT, S_WAIT
	} state_t;

	state_t state_q, ret_q;
	op_t    op_q, ret_op_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			ret_op_q <= OP_NOP;
			op_q     <= OP_NOP;
			ready_q  <= 1'b1;
		end else begin
			op_q <= OP_NOP;
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_DSQ;
						op_q    <= OP_DSQ;
						ready_q <= 1'b0;
					end
				end
				S_DSQ:  begin state_q <= S_DADD; op_q <= OP_DADD; end
				S_DADD: begin state_q <= S_SQRT; op_q <= OP_SQRT; end
				S_SQRT: begin state_q <= S_WAIT; ret_q <= S_DIVN; ret_op_q <= OP_DIVN; end
				S_DIVN: begin state_q <= S_WAIT; ret_q <= S_SATN; ret_op_q <= OP_SATN; end
				S_SATN: state_q <= S_BRANCH;
				S_BRANCH: begin
					if (sts.n_zero) begin
						state_q <= S_GOAL;
						op_q    <= OP_GOAL;
					end else begin
						state_q <= S_DIVX;
						op_q    <= OP_DIVX;
					end
				end
				S_GOAL: begin state_q <= S_FSQ; op_q <= OP_FSQ; end
				S_DIVX: begin state_q <= S_WAIT; ret_q <= S_PX; ret_op_q <= OP_PX; end
				S_PX:   begin state_q <= S_DIVY; op_q <= OP_DIVY; end
				S_DIVY: begin state_q <= S_WAIT; ret_q <= S_PY; ret_op_q <= OP_PY; end
				S_PY:   begin state_q <= S_FSQ; op_q <= OP_FSQ; end
				S_FSQ:  begin state_q <= S_YADD; op_q <= OP_YADD; end
				S_YADD: begin state_q <= S_SQ2; op_q <= OP_SQRT; end
				S_SQ2:  begin state_q <= S_WAIT; ret_q <= S_SM; ret_op_q <= OP_SM; end
				S_SM:   begin state_q <= S_DEN; op_q <= OP_DEN; end
				S_DEN:  begin state_q <= S_XNUM; op_q <= OP_XNUM; end
				S_XNUM: begin state_q <= S_ATANX; op_q <= OP_ATANX; end
				S_ATANX: begin state_q <= S_WAIT; ret_q <= S_MULX; ret_op_q <= OP_MULX; end
				S_MULX:  begin state_q <= S_CODEX; op_q <= OP_CODEX; end
				S_CODEX: begin state_q <= S_ATANY; op_q <= OP_ATANY; end
				S_ATANY: begin state_q <= S_WAIT; ret_q <= S_MULY; ret_op_q <= OP_MULY; end
				S_MULY:  begin state_q <= S_CODEY; op_q <= OP_CODEY; end
				S_CODEY: state_q <= S_EMITW;
				S_EMITW: begin
					if (sts.out_free) begin
						state_q <= S_EMIT;
						op_q    <= OP_EMIT;
					end
				end
				S_EMIT: begin state_q <= S_NEXT; op_q <= OP_NEXT; end
				S_NEXT: begin
					if (sts.last) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end else begin
						state_q <= S_DIVX;
						op_q    <= OP_DIVX;
					end
				end
				S_WAIT: begin
					if (sts.done) begin
						state_q <= ret_q;
						op_q    <= ret_op_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign cmd.op   = op_q;
	assign in_ready = ready_q;

endmodule

FILE: rtl/core/galvo_line_interpolator.sv
// top level of the galvo line interpolator
// each move runs a setup phase, then one point after another, plus output stalls
// (a move of zero steps gives a single point)
// throughput: one move at a time; a move of N points takes setup plus N point times,
// set by the bit-serial sqrt and divider and two cordic runs per point
// reset: config registers take their defaults, last position is zero, output is empty
module galvo_line_interpolator #(
	parameter int MAX_STEPS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gli_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output gli_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import gli_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_fire;

	assign in_fire = in_valid && in_ready;

	gli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	gli_dp #(
		.MAX_STEPS (MAX_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_fire   (in_fire),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_ready (out_ready)
	);

	// no overwrite of a result that has not been transferred
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> (!out_valid || out_ready))
		else $error("emit while output register full");

	// sequencer is quiet while waiting for a goal
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> cmd.op == OP_NOP)
		else $error("command issued while idle");

	// one move at a time
	a_one_move: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input taken during a move");

endmodule
